// ===== hdl/uart_pkg.sv =====
package uart_pkg;

  localparam int BYTE_W      = 8;
  localparam int BIT_TICKS_W = 16;
  localparam int HALF_W      = 15;
  localparam int RX_TIMER_W  = 17;
  localparam int FRAME_W     = 10;
  localparam int COUNT_W     = 4;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_BIT_TICKS      = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HALF_BIT_TICKS = 1'd1;

  localparam logic [BIT_TICKS_W-1:0] BIT_TICKS_RESET      = 16'd104;
  localparam logic [HALF_W-1:0]      HALF_BIT_TICKS_RESET = 15'd52;

  localparam logic [COUNT_W-1:0] TX_FRAME_BITS = 4'd10;
  localparam logic [COUNT_W-1:0] RX_DATA_BITS  = 4'd8;

  typedef struct packed {
    logic              tx_line;
    logic              tx_busy;
    logic [BYTE_W-1:0] received_byte;
    logic              received_valid;
  } uart_result_t;

endpackage

// ===== hdl/uart_if.sv =====
interface uart_tick_if;
  import uart_pkg::*;
  logic              valid;
  logic              ready;
  logic              rx_line;
  logic              send_request;
  logic [BYTE_W-1:0] send_byte;
  modport source(output valid, rx_line, send_request, send_byte, input ready);
  modport sink(input valid, rx_line, send_request, send_byte, output ready);
endinterface

interface uart_result_if;
  import uart_pkg::*;
  logic              valid;
  logic              ready;
  logic              tx_line;
  logic              tx_busy;
  logic [BYTE_W-1:0] received_byte;
  logic              received_valid;
  modport source(output valid, tx_line, tx_busy, received_byte, received_valid,
                 input ready);
  modport sink(input valid, tx_line, tx_busy, received_byte, received_valid,
               output ready);
endinterface

interface uart_cfg_if;
  import uart_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/uart_8n1_transceiver.sv =====
// channel  direction  payload
// tick     in         rx_line, send_request, send_byte
// result   out        tx_line, tx_busy, received_byte, received_valid
// cfg      in         index (0 bit_ticks, 1 half_bit_ticks), data
//
// one tick word per cycle while tick is ready; its result word is registered on acceptance
// the uart state, result register and skid register are the only path a word takes
// a two-deep output stage (result register and skid register) keeps tick
// ready while one result waits; tick stalls only when both are full
// synchronous active-high reset; cfg is always ready
module uart_8n1_transceiver (
  input  logic          clk,
  input  logic          rst,
  uart_cfg_if.sink      cfg,
  uart_tick_if.sink     tick,
  uart_result_if.source result
);
  import uart_pkg::*;

  logic [BIT_TICKS_W-1:0] bit_ticks;
  logic [HALF_W-1:0]      half_bit_ticks;

  logic [FRAME_W-1:0]     tx_frame, tx_frame_next;
  logic [COUNT_W-1:0]     tx_bits_left, tx_bits_left_next;
  logic [BIT_TICKS_W-1:0] tx_timer, tx_timer_next;
  logic                   tx_active, tx_active_next;
  logic                   tx_level, tx_level_next;
  logic                   rx_sampling, rx_sampling_next;
  logic [RX_TIMER_W-1:0]  rx_timer, rx_timer_next;
  logic [BYTE_W-1:0]      rx_shift, rx_shift_next;
  logic [COUNT_W-1:0]     rx_bits_left, rx_bits_left_next;
  logic                   rx_previous_level;
  logic [BYTE_W-1:0]      rx_held, rx_held_next;
  logic                   rx_done;

  uart_result_t res_next;
  uart_result_t out_word;
  uart_result_t skid_word;
  logic         out_valid;
  logic         skid_valid;
  logic         tick_acc;
  logic         out_free;

  assign cfg.ready  = 1'b1;
  assign tick.ready = !skid_valid;
  assign tick_acc   = tick.valid && tick.ready;
  assign out_free   = result.ready || !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks      <= BIT_TICKS_RESET;
      half_bit_ticks <= HALF_BIT_TICKS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_BIT_TICKS:      bit_ticks      <= cfg.data;
        CFG_HALF_BIT_TICKS: half_bit_ticks <= cfg.data[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // transmitter
  always_comb begin
    tx_frame_next     = tx_frame;
    tx_bits_left_next = tx_bits_left;
    tx_timer_next     = tx_timer;
    tx_active_next    = tx_active;
    tx_level_next     = tx_level;
    if (tx_active) begin
      if (tx_timer > BIT_TICKS_W'(1)) begin
        tx_timer_next = tx_timer - BIT_TICKS_W'(1);
      end else begin
        tx_timer_next = bit_ticks;
        if (tx_bits_left == '0) begin
          tx_active_next = 1'b0;
          tx_level_next  = 1'b1;
        end else begin
          tx_level_next     = tx_frame[0];
          tx_frame_next     = {1'b1, tx_frame[FRAME_W-1:1]};
          tx_bits_left_next = tx_bits_left - COUNT_W'(1);
        end
      end
    end else if (tick.send_request) begin
      tx_frame_next     = {1'b1, tick.send_byte, 1'b0};
      tx_bits_left_next = TX_FRAME_BITS;
      tx_timer_next     = bit_ticks;
      tx_active_next    = 1'b1;
      tx_level_next     = 1'b1;
    end
  end

  // receiver
  always_comb begin
    rx_sampling_next  = rx_sampling;
    rx_timer_next     = rx_timer;
    rx_shift_next     = rx_shift;
    rx_bits_left_next = rx_bits_left;
    rx_held_next      = rx_held;
    rx_done           = 1'b0;
    if (rx_sampling) begin
      if (rx_timer > RX_TIMER_W'(1)) begin
        rx_timer_next = rx_timer - RX_TIMER_W'(1);
      end else begin
        rx_shift_next     = {tick.rx_line, rx_shift[BYTE_W-1:1]};
        rx_bits_left_next = rx_bits_left - COUNT_W'(1);
        if (rx_bits_left == COUNT_W'(1)) begin
          rx_held_next      = rx_shift_next;
          rx_done           = 1'b1;
          rx_bits_left_next = RX_DATA_BITS;
          rx_sampling_next  = 1'b0;
        end else begin
          rx_timer_next = RX_TIMER_W'(bit_ticks);
        end
      end
    end else if (rx_previous_level && !tick.rx_line) begin
      rx_sampling_next  = 1'b1;
      rx_timer_next     = RX_TIMER_W'(bit_ticks) + RX_TIMER_W'(half_bit_ticks);
      rx_bits_left_next = RX_DATA_BITS;
    end
  end

  always_comb begin
    res_next.tx_line        = tx_level_next;
    res_next.tx_busy        = tx_active_next;
    res_next.received_byte  = rx_held_next;
    res_next.received_valid = rx_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_frame          <= '1;
      tx_bits_left      <= '0;
      tx_timer          <= '0;
      tx_active         <= 1'b0;
      tx_level          <= 1'b1;
      rx_sampling       <= 1'b0;
      rx_timer          <= '0;
      rx_shift          <= '0;
      rx_bits_left      <= RX_DATA_BITS;
      rx_previous_level <= 1'b1;
      rx_held           <= '0;
    end else if (tick_acc) begin
      tx_frame          <= tx_frame_next;
      tx_bits_left      <= tx_bits_left_next;
      tx_timer          <= tx_timer_next;
      tx_active         <= tx_active_next;
      tx_level          <= tx_level_next;
      rx_sampling       <= rx_sampling_next;
      rx_timer          <= rx_timer_next;
      rx_shift          <= rx_shift_next;
      rx_bits_left      <= rx_bits_left_next;
      rx_previous_level <= tick.rx_line;
      rx_held           <= rx_held_next;
    end
  end

  // output register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= tick_acc;
      end
    end else if (tick_acc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (tick_acc) begin
        out_word <= res_next;
      end
    end else if (tick_acc) begin
      skid_word <= res_next;
    end
  end

  assign result.valid          = out_valid;
  assign result.tx_line        = out_word.tx_line;
  assign result.tx_busy        = out_word.tx_busy;
  assign result.received_byte  = out_word.received_byte;
  assign result.received_valid = out_word.received_valid;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held without a result word");

  a_tx_count_range: assert property (@(posedge clk) disable iff (rst)
    tx_bits_left <= TX_FRAME_BITS)
    else $error("transmit bit count out of range");

  a_rx_count_range: assert property (@(posedge clk) disable iff (rst)
    (rx_bits_left != '0) && (rx_bits_left <= RX_DATA_BITS))
    else $error("receive bit count out of range");

  a_tx_idle_mark: assert property (@(posedge clk) disable iff (rst)
    !tx_active |-> tx_level)
    else $error("transmit line low while idle");

  a_rx_done_ends: assert property (@(posedge clk) disable iff (rst)
    (tick_acc && rx_done) |=> (!rx_sampling && rx_bits_left == RX_DATA_BITS))
    else $error("receiver still sampling after a completed word");
`endif

endmodule
